// ----- rtl/core/stop_and_wait_frame_transmitter_top_macros.svh -----
// Assertion macros for the stop-and-wait frame transmitter checker.
// Used by the checker file; expects clk_i and rst_ni in scope.
`ifndef STOP_AND_WAIT_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define STOP_AND_WAIT_FRAME_TRANSMITTER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWFT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SWFT_ASSERT_NEVER(name, cond, msg) \
  `SWFT_ASSERT(name, !(cond), msg)

`endif

// ----- rtl/core/swft_pkg.sv -----
// Shared types and constants for the stop-and-wait frame transmitter.
// No dependencies.
`timescale 1ns / 1ps

package swft_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int IDX_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int LEN_W         = $clog2(PAYLOAD_DEPTH + 1);

  localparam logic [7:0]  SOF_BYTE      = 8'h02;
  localparam logic [7:0]  EOF_BYTE      = 8'h03;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SOF        = 3'd1,
    PH_LEN        = 3'd2,
    PH_DATA       = 3'd3,
    PH_SUM        = 3'd4,
    PH_EOF        = 3'd5,
    PH_WAIT_FIRST = 3'd6,
    PH_WAIT       = 3'd7
  } phase_e;

endpackage

// ----- rtl/core/swft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/stop_and_wait_frame_transmitter_top.sv -----
// Stop-and-wait frame transmitter top level: sequencer, timeout, output register.
// Depends on swft_pkg and swft_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | cmd, write_index, data_byte, ...
//  out     | output    | out_valid_o/out_stall_i| tx_valid, tx_byte, busy_res, ...
//  cfg     | input     | cfg_valid_i/cfg_ready_o| ack timeout in steps
//
// Writes, starts and non-payload steps: result registered in the cycle after acceptance.
// Payload steps: the payload RAM read is registered first, then the byte is registered as the checksum is folded.
// One transaction in flight at a time; the next is taken as the result is drained.
// Reset clears all control state; payload RAM contents are undefined until written.
// A stalled result holds in the output register and stalls the input side.
`timescale 1ns / 1ps

module stop_and_wait_frame_transmitter_top
  import swft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  write_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  frame_length_i,
  input  logic        ack_seen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  retry_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] send_idx_q, send_idx_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       csum_q, csum_d;
  logic [15:0]      wait_q, wait_d;
  logic [7:0]       retries_q, retries_d;
  logic [15:0]      timeout_q;
  logic             pend_q;
  logic             out_valid_q;
  logic             tx_valid_q, busy_q, done_q;
  logic [7:0]       tx_byte_q, retry_q;

  logic             acc, step_acc, data_acc, fire;
  logic [LEN_W-1:0] send_idx_inc;
  logic [15:0]      wait_nx;
  logic             timed_out;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             tx_valid_c, done_c;
  logic [7:0]       tx_byte_c;
  cmd_e             cmd;

  assign cmd         = cmd_e'(cmd_i);
  assign in_stall_o  = pend_q || (out_valid_q && out_stall_i);
  assign acc         = in_valid_i && !in_stall_o;
  assign step_acc    = acc && (cmd == CMD_STEP);
  assign data_acc    = step_acc && (phase_q == PH_DATA);
  assign fire        = (acc && !data_acc) || pend_q;
  assign cfg_ready_o = 1'b1;

  assign send_idx_inc = send_idx_q + LEN_W'(1);
  assign wait_nx      = (phase_q == PH_WAIT_FIRST) ? 16'd0 :
                        (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;
  assign timed_out    = wait_nx >= timeout_q;

  assign ram_we = acc && (cmd == CMD_WRITE) && (phase_q == PH_IDLE) &&
                  (32'(write_index_i) < PAYLOAD_DEPTH);

  swft_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(write_index_i)),
    .wdata_i (data_byte_i),
    .re_i    (data_acc),
    .raddr_i (send_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    phase_d    = phase_q;
    send_idx_d = send_idx_q;
    len_d      = len_q;
    csum_d     = csum_q;
    wait_d     = wait_q;
    retries_d  = retries_q;
    if (pend_q) begin
      csum_d     = csum_q ^ ram_rdata;
      send_idx_d = send_idx_inc;
      phase_d    = (send_idx_inc >= len_q) ? PH_SUM : PH_DATA;
    end else if (acc) begin
      unique case (cmd)
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            len_d      = (32'(frame_length_i) > PAYLOAD_DEPTH) ? LEN_W'(PAYLOAD_DEPTH)
                                                            : LEN_W'(frame_length_i);
            retries_d  = 8'd0;
            send_idx_d = '0;
            csum_d     = 8'd0;
            wait_d     = 16'd0;
            phase_d    = PH_SOF;
          end
        end
        CMD_STEP: begin
          unique case (phase_q) inside
            PH_SOF: begin
              csum_d     = 8'd0;
              send_idx_d = '0;
              phase_d    = PH_LEN;
            end
            PH_LEN:  phase_d = (len_q == '0) ? PH_SUM : PH_DATA;
            PH_SUM:  phase_d = PH_EOF;
            PH_EOF:  phase_d = PH_WAIT_FIRST;
            PH_WAIT_FIRST, PH_WAIT: begin
              wait_d  = wait_nx;
              phase_d = PH_WAIT;
              if (ack_seen_i) begin
                phase_d = PH_IDLE;
              end else if (timed_out) begin
                if (retries_q != 8'hFF) begin
                  retries_d = retries_q + 8'd1;
                end
                csum_d     = 8'd0;
                send_idx_d = '0;
                phase_d    = PH_LEN;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result fields
  always_comb begin
    tx_valid_c = 1'b0;
    tx_byte_c  = 8'd0;
    done_c     = 1'b0;
    if (pend_q) begin
      tx_valid_c = 1'b1;
      tx_byte_c  = ram_rdata;
    end else if (step_acc) begin
      unique case (phase_q) inside
        PH_SOF: begin
          tx_valid_c = 1'b1;
          tx_byte_c  = SOF_BYTE;
        end
        PH_LEN: begin
          tx_valid_c = 1'b1;
          tx_byte_c  = 8'(len_q);
        end
        PH_SUM: begin
          tx_valid_c = 1'b1;
          tx_byte_c  = csum_q;
        end
        PH_EOF: begin
          tx_valid_c = 1'b1;
          tx_byte_c  = EOF_BYTE;
        end
        PH_WAIT_FIRST, PH_WAIT: begin
          if (ack_seen_i) begin
            done_c = 1'b1;
          end else if (timed_out) begin
            tx_valid_c = 1'b1;
            tx_byte_c  = SOF_BYTE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      send_idx_q  <= '0;
      len_q       <= '0;
      csum_q      <= 8'd0;
      wait_q      <= 16'd0;
      retries_q   <= 8'd0;
      timeout_q   <= TIMEOUT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      send_idx_q  <= send_idx_d;
      len_q       <= len_d;
      csum_q      <= csum_d;
      wait_q      <= wait_d;
      retries_q   <= retries_d;
      pend_q      <= data_acc;
      out_valid_q <= fire || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tx_valid_q <= tx_valid_c;
      tx_byte_q  <= tx_byte_c;
      busy_q     <= (phase_d != PH_IDLE);
      done_q     <= done_c;
      retry_q    <= retries_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign retry_count_o = retry_q;

endmodule

// ----- rtl/core/swft_checker.sv -----
// Port-level checker for the stop-and-wait frame transmitter, bound to the top level.
// Depends on stop_and_wait_frame_transmitter_top_macros.svh.
`timescale 1ns / 1ps
`include "stop_and_wait_frame_transmitter_top_macros.svh"

module swft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        tx_valid_o,
  input logic [7:0]  tx_byte_o,
  input logic        busy_res_o,
  input logic        done_res_o
);

  `SWFT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o), "stalled transaction changed")
  `SWFT_ASSERT_NEVER(a_done_busy, out_valid_o && done_res_o && (busy_res_o || tx_valid_o), "done with busy or byte")
  `SWFT_ASSERT_NEVER(a_tx_idle, out_valid_o && tx_valid_o && !busy_res_o, "byte sent while idle")
  `SWFT_ASSERT(a_accept_result, in_valid_i && !in_stall_o |=> out_valid_o || in_stall_o, "accepted transaction lost")

endmodule

bind stop_and_wait_frame_transmitter_top swft_checker u_swft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tx_valid_o  (tx_valid_o),
  .tx_byte_o   (tx_byte_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o)
);
